// ===== hw/rtl/ntca2t_pkg.sv =====
// Shared types, constants and the calibration ROM for the NTC sample to
// temperature converter. No dependencies; used by every module of the block.

package ntca2t_pkg;

  localparam int TABLE_ENTRIES = 201;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int STEP_W        = $clog2(IDX_W);
  localparam int SAMPLE_W      = 16;
  localparam int NUM_W         = SAMPLE_W + 3;
  localparam int QUO_W         = 3;
  localparam int DEG_W         = 7;
  localparam int TENTHS_W      = 10;

  localparam logic [IDX_W-1:0]    SEG_LAST     = IDX_W'(TABLE_ENTRIES - 2);
  localparam logic [STEP_W-1:0]   SEARCH_FIRST = STEP_W'(IDX_W - 1);
  localparam logic [STEP_W-1:0]   DIV_FIRST    = STEP_W'(QUO_W - 1);
  localparam logic [NUM_W-1:0]    STEP_TENTHS  = NUM_W'(5);
  localparam logic [TENTHS_W-1:0] DEG_TENTHS   = TENTHS_W'(10);
  localparam logic [DEG_W-1:0]    OVER_DEGREES = DEG_W'(99);

  typedef enum logic [1:0] {
    RC_BELOW = 2'd0,
    RC_IN    = 2'd1,
    RC_ABOVE = 2'd2
  } range_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SPAN,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic              load;
    logic              search_step;
    logic              span_load;
    logic              div_step;
    logic              out_load;
    logic [STEP_W-1:0] bit_sel;
  } cmd_t;

  typedef struct packed {
    logic in_range;
    logic out_free;
  } status_t;

  // Ascending ADC readings, 0.0 to 100.0 degC in half-degree steps
  localparam logic [SAMPLE_W-1:0] NTC_ROM [TABLE_ENTRIES] = '{
    16'd15419,16'd15719,16'd16022,16'd16328,16'd16638,16'd16950,16'd17265,16'd17582,
    16'd17903,16'd18226,16'd18552,16'd18880,16'd19211,16'd19544,16'd19880,16'd20217,
    16'd20557,16'd20899,16'd21243,16'd21589,16'd21937,16'd22286,16'd22637,16'd22990,
    16'd23344,16'd23700,16'd24057,16'd24415,16'd24774,16'd25134,16'd25495,16'd25857,
    16'd26220,16'd26583,16'd26947,16'd27311,16'd27676,16'd28041,16'd28406,16'd28772,
    16'd29137,16'd29502,16'd29867,16'd30231,16'd30596,16'd30959,16'd31322,16'd31685,
    16'd32047,16'd32407,16'd32768,16'd33126,16'd33484,16'd33841,16'd34197,16'd34551,
    16'd34904,16'd35255,16'd35605,16'd35953,16'd36299,16'd36644,16'd36987,16'd37328,
    16'd37667,16'd38004,16'd38339,16'd38672,16'd39003,16'd39332,16'd39658,16'd39982,
    16'd40303,16'd40623,16'd40940,16'd41254,16'd41566,16'd41875,16'd42182,16'd42486,
    16'd42787,16'd43086,16'd43382,16'd43676,16'd43966,16'd44254,16'd44539,16'd44822,
    16'd45101,16'd45378,16'd45652,16'd45923,16'd46191,16'd46456,16'd46719,16'd46978,
    16'd47235,16'd47489,16'd47740,16'd47988,16'd48234,16'd48476,16'd48716,16'd48952,
    16'd49186,16'd49417,16'd49646,16'd49871,16'd50094,16'd50314,16'd50531,16'd50746,
    16'd50957,16'd51166,16'd51373,16'd51576,16'd51777,16'd51975,16'd52171,16'd52364,
    16'd52554,16'd52742,16'd52928,16'd53110,16'd53290,16'd53468,16'd53644,16'd53816,
    16'd53987,16'd54155,16'd54321,16'd54484,16'd54645,16'd54804,16'd54961,16'd55115,
    16'd55267,16'd55417,16'd55565,16'd55710,16'd55853,16'd55995,16'd56134,16'd56272,
    16'd56407,16'd56540,16'd56671,16'd56800,16'd56928,16'd57053,16'd57176,16'd57298,
    16'd57418,16'd57536,16'd57653,16'd57767,16'd57880,16'd57991,16'd58101,16'd58209,
    16'd58315,16'd58420,16'd58522,16'd58624,16'd58724,16'd58822,16'd58919,16'd59014,
    16'd59108,16'd59201,16'd59292,16'd59381,16'd59470,16'd59557,16'd59642,16'd59727,
    16'd59809,16'd59891,16'd59971,16'd60051,16'd60129,16'd60206,16'd60281,16'd60356,
    16'd60429,16'd60501,16'd60572,16'd60642,16'd60711,16'd60779,16'd60846,16'd60912,
    16'd60976,16'd61040,16'd61103,16'd61165,16'd61226,16'd61286,16'd61345,16'd61403,
    16'd61460
  };

  // Out-of-table addresses read as zero
  function automatic logic [SAMPLE_W-1:0] rom_read(input logic [IDX_W-1:0] idx);
    logic [SAMPLE_W-1:0] val;
    val = '0;
    if (int'(idx) < TABLE_ENTRIES) begin
      val = NTC_ROM[idx];
    end
    return val;
  endfunction

endpackage

// ===== hw/rtl/ntca2t_ctrl.sv =====
// Sequencer for the NTC converter: binary search, span fetch, serial divide
// and result hand-off. Depends on ntca2t_pkg; drives ntca2t_datapath.

module ntca2t_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  ntca2t_pkg::status_t status,
  output ntca2t_pkg::cmd_t    cmd
);

  ntca2t_pkg::state_t                  state, state_next;
  logic [ntca2t_pkg::STEP_W-1:0]       cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ntca2t_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next       = state;
    cnt_next         = cnt;
    sample_stall     = 1'b1;
    cmd              = '0;
    cmd.bit_sel      = cnt;
    case (state)
      ntca2t_pkg::ST_IDLE: begin
        sample_stall = 1'b0;
        if (sample_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = ntca2t_pkg::SEARCH_FIRST;
          state_next = ntca2t_pkg::ST_SEARCH;
        end
      end
      ntca2t_pkg::ST_SEARCH: begin
        if (!status.in_range) begin
          state_next = ntca2t_pkg::ST_FINISH;
        end else begin
          cmd.search_step = 1'b1;
          if (cnt == '0) begin
            state_next = ntca2t_pkg::ST_SPAN;
          end else begin
            cnt_next = cnt - 1'b1;
          end
        end
      end
      ntca2t_pkg::ST_SPAN: begin
        cmd.span_load = 1'b1;
        cnt_next      = ntca2t_pkg::DIV_FIRST;
        state_next    = ntca2t_pkg::ST_DIVIDE;
      end
      ntca2t_pkg::ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (cnt == '0) begin
          state_next = ntca2t_pkg::ST_FINISH;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      ntca2t_pkg::ST_FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ntca2t_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ntca2t_pkg::ST_IDLE;
      end
    endcase
  end

  // Search runs only on in-table samples
  a_search_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.search_step |-> status.in_range)
    else $error("search step on out-of-range sample");

  // A new sample is taken only after the previous result has been handed off
  a_load_after_out: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> state == ntca2t_pkg::ST_IDLE && !$past(state == ntca2t_pkg::ST_SEARCH))
    else $error("sample taken mid-conversion");

  // Divide always starts from the top quotient bit
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    cmd.span_load |=> cmd.div_step && cmd.bit_sel == ntca2t_pkg::DIV_FIRST)
    else $error("divide did not start at top bit");

endmodule

// ===== hw/rtl/ntca2t_datapath.sv =====
// Datapath for the NTC converter: sample and range registers, search index,
// remainder/quotient divider and output register. Depends on ntca2t_pkg.

module ntca2t_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  ntca2t_pkg::cmd_t                      cmd,
  output ntca2t_pkg::status_t                   status,
  input  logic [ntca2t_pkg::SAMPLE_W-1:0]       adc_sample,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic [ntca2t_pkg::DEG_W-1:0]          temp_degrees,
  output logic [ntca2t_pkg::TENTHS_W-1:0]       temp_tenths,
  output logic [1:0]                            range_code
);

  logic [ntca2t_pkg::SAMPLE_W-1:0] sample;
  ntca2t_pkg::range_t              range_q;
  logic [ntca2t_pkg::IDX_W-1:0]    k;
  logic [ntca2t_pkg::NUM_W-1:0]    rem;
  logic [ntca2t_pkg::SAMPLE_W-1:0] span;
  logic [ntca2t_pkg::QUO_W-1:0]    quo;

  logic [ntca2t_pkg::IDX_W-1:0]    cand;
  logic [ntca2t_pkg::SAMPLE_W-1:0] cand_val;
  logic [ntca2t_pkg::SAMPLE_W-1:0] lo_val;
  logic [ntca2t_pkg::SAMPLE_W-1:0] hi_val;
  logic [ntca2t_pkg::NUM_W-1:0]    span_sh;
  ntca2t_pkg::range_t              range_in;
  logic [3:0]                      part;
  logic [ntca2t_pkg::TENTHS_W-1:0] tenths_in;
  logic [ntca2t_pkg::DEG_W-1:0]    degrees_in;

  always_comb begin
    if (adc_sample < ntca2t_pkg::NTC_ROM[0]) begin
      range_in = ntca2t_pkg::RC_BELOW;
    end else if (adc_sample > ntca2t_pkg::NTC_ROM[ntca2t_pkg::TABLE_ENTRIES-1]) begin
      range_in = ntca2t_pkg::RC_ABOVE;
    end else begin
      range_in = ntca2t_pkg::RC_IN;
    end
  end

  assign cand     = k | (ntca2t_pkg::IDX_W'(1) << cmd.bit_sel);
  assign cand_val = ntca2t_pkg::rom_read(cand);
  assign lo_val   = ntca2t_pkg::rom_read(k);
  assign hi_val   = ntca2t_pkg::rom_read(k + 1'b1);
  assign span_sh  = ntca2t_pkg::NUM_W'(span) << cmd.bit_sel;

  // Odd segments start half a degree up
  assign part       = (k[0] ? 4'd5 : 4'd0) + 4'(quo);
  assign tenths_in  = ntca2t_pkg::TENTHS_W'(k[ntca2t_pkg::IDX_W-1:1]) * ntca2t_pkg::DEG_TENTHS
                      + ntca2t_pkg::TENTHS_W'(part);
  assign degrees_in = ntca2t_pkg::DEG_W'(k[ntca2t_pkg::IDX_W-1:1])
                      + ntca2t_pkg::DEG_W'(part >= 4'd10);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample  <= adc_sample;
      range_q <= range_in;
      k       <= '0;
    end
    if (cmd.search_step) begin
      if (cand <= ntca2t_pkg::SEG_LAST && cand_val <= sample) begin
        k <= cand;
      end
    end
    if (cmd.span_load) begin
      rem  <= ntca2t_pkg::NUM_W'(sample - lo_val) * ntca2t_pkg::STEP_TENTHS;
      span <= hi_val - lo_val;
      quo  <= '0;
    end
    if (cmd.div_step) begin
      // Flat segment leaves the fraction at zero
      if (span != '0 && rem >= span_sh) begin
        rem           <= rem - span_sh;
        quo[cmd.bit_sel[1:0]] <= 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (range_q)
        ntca2t_pkg::RC_BELOW: begin
          temp_degrees <= '0;
          temp_tenths  <= '0;
        end
        ntca2t_pkg::RC_ABOVE: begin
          temp_degrees <= ntca2t_pkg::OVER_DEGREES;
          temp_tenths  <= ntca2t_pkg::TENTHS_W'(ntca2t_pkg::OVER_DEGREES)
                          * ntca2t_pkg::DEG_TENTHS;
        end
        default: begin
          temp_degrees <= degrees_in;
          temp_tenths  <= tenths_in;
        end
      endcase
      range_code <= range_q;
    end
  end

  assign status.in_range = (range_q == ntca2t_pkg::RC_IN);
  assign status.out_free = !result_valid || !result_stall;

  // Never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(result_valid && result_stall))
    else $error("result overwritten");

  // Search never leaves the segment range
  a_seg_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.span_load |-> k <= ntca2t_pkg::SEG_LAST)
    else $error("segment index out of range");

  // Interpolated fraction stays within one half-degree step
  a_frac_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load && range_q == ntca2t_pkg::RC_IN |-> quo <= 3'd5)
    else $error("fraction exceeds step");

endmodule

// ===== hw/rtl/ntc_adc_to_temperature.sv =====
// NTC thermistor ADC sample to temperature, top level.
// Per sample in table: 8-step ROM search, span fetch, 3-step divide, hand-off;
//   out of range the sequencer goes straight to the hand-off. One sample at a
//   time: no new sample is taken until the last result is handed off.
// Reset: rst synchronous, active high; clears the sequencer and result_valid.
// Depends on ntca2t_pkg, ntca2t_ctrl and ntca2t_datapath.

module ntc_adc_to_temperature (
  input  logic                            clk,
  input  logic                            rst,
  // sample channel
  input  logic                            sample_valid,
  output logic                            sample_stall,
  input  logic [ntca2t_pkg::SAMPLE_W-1:0] adc_sample,
  // result channel
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [ntca2t_pkg::DEG_W-1:0]    temp_degrees,
  output logic [ntca2t_pkg::TENTHS_W-1:0] temp_tenths,
  output logic [1:0]                      range_code
);

  // Command and status between sequencer and datapath
  ntca2t_pkg::cmd_t    cmd;
  ntca2t_pkg::status_t status;

  // Sequencer: take one sample, walk the search and divide, then hold the
  // finished result until the output register is free.
  ntca2t_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .status       (status),
    .cmd          (cmd)
  );

  // Datapath: segment index by binary search over the ROM, then
  // (sample - lo) * 5 / span one quotient bit per cycle, then scale to
  // tenths and whole degrees. The output register lets a new sample be
  // transferred while the last result waits downstream.
  ntca2t_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .adc_sample   (adc_sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .temp_degrees (temp_degrees),
    .temp_tenths  (temp_tenths),
    .range_code   (range_code)
  );

endmodule

// ===== dv/ntc_adc_to_temperature_tb.sv =====
// Self-checking testbench for the NTC sample to temperature converter.
// Depends on ntca2t_pkg for widths, the range codes and the calibration ROM,
// and on the ntc_adc_to_temperature block with its sub-modules.
`timescale 1ns / 100ps

module ntc_adc_to_temperature_tb;

  localparam int unsigned HALF_DEG_TENTHS = 5;
  localparam int unsigned TENTHS_PER_DEG  = 10;
  localparam int unsigned OVER_DEG        = 99;
  localparam int unsigned RANDOM_SAMPLES  = 1130;
  localparam int unsigned GAP_MAX         = 14;
  localparam int unsigned HOLD_AT_RESULT  = 300;   // start the long hold-off here
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned DRAIN_CYCLES    = 40;
  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned REPORT_LIMIT    = 10;

  typedef struct packed {
    logic [ntca2t_pkg::DEG_W-1:0]    degrees;
    logic [ntca2t_pkg::TENTHS_W-1:0] tenths;
    ntca2t_pkg::range_t              code;
  } temp_reading_t;

  typedef struct {
    logic [ntca2t_pkg::SAMPLE_W-1:0] value;
    int unsigned                     gap;
  } sample_item_t;

  logic                            clk          = 1'b0;
  logic                            rst          = 1'b1;
  logic                            sample_valid = 1'b0;
  logic                            sample_stall;
  logic [ntca2t_pkg::SAMPLE_W-1:0] adc_sample   = '0;
  logic                            result_valid;
  logic                            result_stall = 1'b0;
  logic [ntca2t_pkg::DEG_W-1:0]    temp_degrees;
  logic [ntca2t_pkg::TENTHS_W-1:0] temp_tenths;
  logic [1:0]                      range_code;

  sample_item_t  sample_pending[$];
  temp_reading_t reading_expected[$];

  int unsigned samples_sent;
  int unsigned readings_seen;
  int unsigned failures;
  int unsigned below_seen, inside_seen, above_seen;
  int unsigned sender_wait;
  int unsigned stall_left;
  int unsigned hold_left;
  bit          hold_done;
  int unsigned cycle_count;

  ntc_adc_to_temperature DUT (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .adc_sample   (adc_sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .temp_degrees (temp_degrees),
    .temp_tenths  (temp_tenths),
    .range_code   (range_code)
  );

  always #5 clk = ~clk;

  // Expected reading for one sample: clamp below and above the table, else
  // find the first segment that holds the sample and interpolate inside it.
  function automatic temp_reading_t convert_sample(
    input logic [ntca2t_pkg::SAMPLE_W-1:0] s
  );
    temp_reading_t r;
    int unsigned   lo, hi, span, frac, tenths;
    bit            found;
    r.degrees = '0;
    r.tenths  = '0;
    r.code    = ntca2t_pkg::RC_BELOW;
    found     = 1'b0;
    tenths    = 0;
    if (s > ntca2t_pkg::NTC_ROM[ntca2t_pkg::TABLE_ENTRIES-1]) begin
      r.degrees = ntca2t_pkg::DEG_W'(OVER_DEG);
      r.tenths  = ntca2t_pkg::TENTHS_W'(OVER_DEG * TENTHS_PER_DEG);
      r.code    = ntca2t_pkg::RC_ABOVE;
    end else if (s >= ntca2t_pkg::NTC_ROM[0]) begin
      for (int k = 0; k + 1 < ntca2t_pkg::TABLE_ENTRIES; k++) begin
        lo = ntca2t_pkg::NTC_ROM[k];
        hi = ntca2t_pkg::NTC_ROM[k+1];
        if (!found && s >= lo && s <= hi) begin
          found = 1'b1;
          span  = hi - lo;
          frac  = (span != 0) ? ((s - lo) * HALF_DEG_TENTHS) / span : 0;
          tenths = (k / 2) * TENTHS_PER_DEG + (k % 2) * HALF_DEG_TENTHS + frac;
        end
      end
      r.tenths  = ntca2t_pkg::TENTHS_W'(tenths);
      r.degrees = ntca2t_pkg::DEG_W'(tenths / TENTHS_PER_DEG);
      r.code    = ntca2t_pkg::RC_IN;
    end
    return r;
  endfunction

  // Mostly in-table readings, some sitting on or next to a ROM entry, some
  // anywhere in the 16-bit range.
  function automatic logic [ntca2t_pkg::SAMPLE_W-1:0] draw_sample();
    int unsigned pick;
    int          v;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      v = $urandom_range(ntca2t_pkg::NTC_ROM[0],
                         ntca2t_pkg::NTC_ROM[ntca2t_pkg::TABLE_ENTRIES-1]);
    end else if (pick < 85) begin
      v = int'(ntca2t_pkg::NTC_ROM[$urandom_range(0, ntca2t_pkg::TABLE_ENTRIES-1)])
          + $urandom_range(0, 2) - 1;
    end else begin
      v = $urandom_range(0, 65535);
    end
    return ntca2t_pkg::SAMPLE_W'(v);
  endfunction

  function automatic void report_failure(input string what);
    if (failures < REPORT_LIMIT) begin
      $display("[%0t] ERROR: %s", $realtime, what);
    end
    failures++;
  endfunction

  // Sample driver: hold a stalled transfer, otherwise wait out the head item's
  // gap and present it.
  always @(posedge clk) begin : sample_driver
    sample_item_t item;
    logic         free;
    if (rst) begin
      sample_valid <= 1'b0;
      sender_wait  <= 0;
    end else begin
      free = !sample_valid || !sample_stall;
      if (sample_valid && !sample_stall) begin
        reading_expected.push_back(convert_sample(adc_sample));
        samples_sent++;
      end
      if (free) begin
        if (sample_pending.size() > 0 && sender_wait >= sample_pending[0].gap) begin
          item = sample_pending.pop_front();
          adc_sample   <= item.value;
          sample_valid <= 1'b1;
          sender_wait  <= 0;
        end else begin
          sample_valid <= 1'b0;
          if (sample_pending.size() > 0) begin
            sender_wait <= sender_wait + 1;
          end
        end
      end
    end
  end

  // Result monitor: check each transfer against the oldest expectation, then
  // draw the stall before the next one. Once, hold off for a long stretch so
  // the block backs up into the sample channel.
  always @(posedge clk) begin : result_monitor
    temp_reading_t want;
    int unsigned   pause, hold;
    if (rst) begin
      result_stall <= 1'b0;
      stall_left   <= 0;
      hold_left    <= 0;
    end else begin
      pause = stall_left;
      hold  = hold_left;
      if (result_valid && !result_stall) begin
        readings_seen++;
        if (reading_expected.size() == 0) begin
          report_failure($sformatf("reading with none expected: deg %0d tenths %0d code %0d",
                                   temp_degrees, temp_tenths, range_code));
        end else begin
          want = reading_expected.pop_front();
          case (want.code)
            ntca2t_pkg::RC_BELOW: below_seen++;
            ntca2t_pkg::RC_IN:    inside_seen++;
            default:              above_seen++;
          endcase
          if (temp_degrees !== want.degrees || temp_tenths !== want.tenths ||
              range_code !== want.code) begin
            report_failure($sformatf(
              "reading %0d: deg %0d/%0d tenths %0d/%0d code %0d/%0d (got/expected)",
              readings_seen, temp_degrees, want.degrees, temp_tenths, want.tenths,
              range_code, want.code));
          end
        end
        // Alternate bands of free flow with bands of random back-pressure
        pause = ((readings_seen % 250) < 80) ? 0 : $urandom_range(0, GAP_MAX);
        if (!hold_done && readings_seen == HOLD_AT_RESULT) begin
          hold      = HOLD_CYCLES;
          hold_done = 1'b1;
        end
      end
      if (hold > 0) begin
        result_stall <= 1'b1;
        hold_left    <= hold - 1;
        stall_left   <= pause;
      end else if (pause > 0) begin
        result_stall <= 1'b1;
        stall_left   <= pause - 1;
        hold_left    <= 0;
      end else begin
        result_stall <= 1'b0;
        stall_left   <= 0;
        hold_left    <= 0;
      end
    end
  end

  // Watchdog: stop a hung run
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d readings outstanding",
               cycle_count, reading_expected.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    sample_item_t                    item;
    logic [ntca2t_pkg::SAMPLE_W-1:0] directed[$];
    // Field extremes, both values of every bit, both table ends and their
    // neighbours, entry boundaries and points inside segments
    directed = '{16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555,
                 ntca2t_pkg::NTC_ROM[0] - 16'd1, ntca2t_pkg::NTC_ROM[0],
                 ntca2t_pkg::NTC_ROM[0] + 16'd1,
                 ntca2t_pkg::NTC_ROM[1] - 16'd1, ntca2t_pkg::NTC_ROM[1],
                 ntca2t_pkg::NTC_ROM[2],
                 ntca2t_pkg::NTC_ROM[50], ntca2t_pkg::NTC_ROM[100] + 16'd1,
                 ntca2t_pkg::NTC_ROM[101] - 16'd1,
                 ntca2t_pkg::NTC_ROM[199], ntca2t_pkg::NTC_ROM[199] + 16'd1,
                 ntca2t_pkg::NTC_ROM[ntca2t_pkg::TABLE_ENTRIES-1] - 16'd1,
                 ntca2t_pkg::NTC_ROM[ntca2t_pkg::TABLE_ENTRIES-1],
                 ntca2t_pkg::NTC_ROM[ntca2t_pkg::TABLE_ENTRIES-1] + 16'd1,
                 16'd40000, 16'd61000};
    foreach (directed[i]) begin
      item.value = directed[i];
      item.gap   = 0;
      sample_pending.push_back(item);
    end
    for (int n = 0; n < RANDOM_SAMPLES; n++) begin
      item.value = draw_sample();
      // Bursts with no gaps, then stretches of random idling
      item.gap   = ((n % 300) < 100) ? 0 : $urandom_range(0, GAP_MAX);
      sample_pending.push_back(item);
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (sample_pending.size() > 0 || sample_valid || reading_expected.size() > 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (reading_expected.size() > 0) begin
      report_failure($sformatf("%0d readings never arrived", reading_expected.size()));
    end

    $display("Sent %0d samples, checked %0d readings in %0d cycles",
             samples_sent, readings_seen, cycle_count);
    $display("Readings below table %0d, in table %0d, above table %0d; failures %0d",
             below_seen, inside_seen, above_seen, failures);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
